// ===== rtl/assert_macros.svh =====
// assertion macros used by category_set_insert_lookup_unit
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every clock edge out of reset
`define CSIL_ASSERT(label, clk, rst, prop) \
    label: assert property (@(posedge clk) disable iff (rst) (prop)) \
        else $error("assertion failed");

// implication checked on every clock edge out of reset
`define CSIL_ASSERT_IMP(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

// ===== rtl/csil_pkg.sv =====
// constants and codes for the category set insert and lookup unit
// no dependencies
`timescale 1ns / 1ps

package csil_pkg;

    localparam int CAPACITY = 16;
    localparam int CAT_W    = 64;
    localparam int FILL_W   = 5;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

endpackage

// ===== rtl/csil_if.sv =====
// request and result channel interfaces
// depends on csil_pkg
`timescale 1ns / 1ps

interface csil_in_if;
    import csil_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic [CAT_W-1:0] category;

    modport source (output valid, output func, output category, input ready);
    modport sink   (input valid, input func, input category, output ready);
endinterface

interface csil_out_if;
    import csil_pkg::*;

    logic              valid;
    logic              ready;
    logic              present;
    logic              status;
    logic [FILL_W-1:0] fill_count;

    modport source (output valid, output present, output status, output fill_count,
                    input ready);
    modport sink   (input valid, input present, input status, input fill_count,
                    output ready);
endinterface

// ===== rtl/category_set_insert_lookup_unit.sv =====
// category set insert and lookup unit: slot store, scan sequencer, result register
// depends on csil_pkg, csil_if and assert_macros.svh
//
//   channel  dir  payload                          transfer when
//   i_in     in   func, category                   valid && ready
//   o_out    out  present, status, fill_count      valid && ready
//
// one item passes through the accepting idle state, a scan of the used slots with one slot compare
// per cycle through the single 64-bit comparator and an end-of-scan step, then a commit step that
// waits for the output register to be free; a match ends the scan early
// i_in.ready is high only while the sequencer is idle
// a finished result sits in the output register; the next item is scanned meanwhile
// and its commit waits until that result has been transferred
// reset clears the fill count and the control state; slot contents are not cleared
`timescale 1ns / 1ps
`include "assert_macros.svh"

module category_set_insert_lookup_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csil_in_if.sink     i_in,
    csil_out_if.source  o_out
);
    import csil_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT} t_state;

    t_state             r_state;
    logic               r_func;
    logic [CAT_W-1:0]   r_cat;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_used;
    logic               r_found;
    logic               r_hole_ok;
    logic [IDX_W-1:0]   r_hole_idx;
    logic               r_out_valid;
    logic               r_out_present;
    logic               r_out_status;
    logic [FILL_W-1:0]  r_out_fill;

    logic [CAT_W-1:0]   r_slots [CAPACITY];

    logic [CAT_W-1:0]   w_rd;
    logic               w_go;
    logic               w_ins;
    logic               w_room;
    logic               w_write;
    logic [IDX_W-1:0]   w_waddr;
    logic [CNT_W-1:0]   n_used;
    logic               n_status;

    assign w_rd = r_slots[r_idx[IDX_W-1:0]];
    assign w_go = !r_out_valid || o_out.ready;

    // insert decision for the commit cycle
    always_comb begin
        w_ins    = (r_func == FUNC_ADD) && !r_found;
        w_room   = r_used < CNT_W'(CAPACITY);
        w_write  = 1'b0;
        w_waddr  = r_hole_idx;
        n_used   = r_used;
        n_status = STATUS_OK;
        if (w_ins) begin
            if (r_hole_ok) begin
                w_write = 1'b1;
            end else if (w_room) begin
                w_write = 1'b1;
                w_waddr = r_used[IDX_W-1:0];
                n_used  = r_used + CNT_W'(1);
            end else begin
                n_status = STATUS_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_COMMIT && w_go && w_write) begin
            r_slots[w_waddr] <= r_cat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_hole_ok   <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_func    <= i_in.func;
                        r_cat     <= i_in.category;
                        r_idx     <= '0;
                        r_found   <= 1'b0;
                        r_hole_ok <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx == r_used) begin
                        r_state <= S_COMMIT;
                    end else if (w_rd == r_cat) begin
                        r_found <= 1'b1;
                        r_state <= S_COMMIT;
                    end else begin
                        if (w_rd == '0 && !r_hole_ok) begin
                            r_hole_ok  <= 1'b1;
                            r_hole_idx <= r_idx[IDX_W-1:0];
                        end
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                S_COMMIT: begin
                    if (w_go) begin
                        r_used        <= n_used;
                        r_out_valid   <= 1'b1;
                        r_out_present <= r_found;
                        r_out_status  <= n_status;
                        r_out_fill    <= FILL_W'(n_used);
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.present    = r_out_present;
    assign o_out.status     = r_out_status;
    assign o_out.fill_count = r_out_fill;

    `CSIL_ASSERT(a_used_bound, i_clk, !i_rst_n, r_used <= CNT_W'(CAPACITY))
    `CSIL_ASSERT(a_used_grows, i_clk, !i_rst_n, r_used >= $past(r_used))
    `CSIL_ASSERT_IMP(a_scan_bound, i_clk, !i_rst_n, r_state == S_SCAN, r_idx <= r_used)
    `CSIL_ASSERT_IMP(a_full_only_at_cap, i_clk, !i_rst_n,
        r_out_valid && r_out_status == STATUS_FULL, r_used == CNT_W'(CAPACITY))

endmodule

// ===== tb/sv/tb_category_set_insert_lookup_unit.sv =====
// testbench for category_set_insert_lookup_unit: directed and random adds and queries,
// checked against a tracked copy of the set held in a small scoreboard class
// depends on csil_pkg, csil_if and the rtl of the unit
`timescale 1ns / 1ps

module tb_category_set_insert_lookup_unit;
    import csil_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic              present;
        logic              status;
        logic [FILL_W-1:0] fill_count;
    } t_outcome;

    class membership_tracker;
        logic [CAT_W-1:0] slots [CAPACITY];
        int unsigned      fill;
        t_outcome         expected_outcomes [$];
        int               errors;
        int               n_add;
        int               n_query;
        int               n_found;
        int               n_refused;
        int               n_checked;
        int unsigned      peak_fill;

        function new();
            fill      = 0;
            errors    = 0;
            n_add     = 0;
            n_query   = 0;
            n_found   = 0;
            n_refused = 0;
            n_checked = 0;
            peak_fill = 0;
        endfunction

        function void note_request(logic func, logic [CAT_W-1:0] cat);
            t_outcome res;
            bit       found;
            bit       placed;
            found  = 0;
            placed = 0;
            for (int i = 0; i < fill; i++)
                if (slots[i] == cat)
                    found = 1;
            res.status = STATUS_OK;
            if (func == FUNC_ADD) begin
                n_add++;
                if (!found) begin
                    // a hole below the fill count is reused first
                    for (int i = 0; i < fill; i++) begin
                        if (!placed && slots[i] == '0) begin
                            slots[i] = cat;
                            placed   = 1;
                        end
                    end
                    if (!placed) begin
                        if (fill >= CAPACITY) begin
                            res.status = STATUS_FULL;
                            n_refused++;
                        end else begin
                            slots[fill] = cat;
                            fill++;
                        end
                    end
                end
            end else begin
                n_query++;
            end
            if (found)
                n_found++;
            if (fill > peak_fill)
                peak_fill = fill;
            res.present    = found;
            res.fill_count = FILL_W'(fill);
            expected_outcomes.push_back(res);
        endfunction

        function void check_outcome(logic present, logic status, logic [FILL_W-1:0] fill_count);
            t_outcome exp;
            if (expected_outcomes.size() == 0) begin
                $display("%0t: result with nothing pending: present %0h status %0h fill %0d",
                         $time, present, status, fill_count);
                errors++;
                return;
            end
            exp = expected_outcomes.pop_front();
            n_checked++;
            if (present !== exp.present) begin
                $display("%0t: present mismatch, expected %0h, actual %0h",
                         $time, exp.present, present);
                errors++;
            end
            if (status !== exp.status) begin
                $display("%0t: status mismatch, expected %0h, actual %0h",
                         $time, exp.status, status);
                errors++;
            end
            if (fill_count !== exp.fill_count) begin
                $display("%0t: fill_count mismatch, expected %0d, actual %0d",
                         $time, exp.fill_count, fill_count);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_outcomes.size();
        endfunction

        function logic [CAT_W-1:0] any_member();
            if (fill == 0)
                return {$urandom, $urandom};
            return slots[$urandom_range(fill - 1)];
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   calm;
    bit   hold_request;

    membership_tracker tracker;

    csil_in_if  in_if ();
    csil_out_if out_if ();

    category_set_insert_lookup_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("%0t: timed out", $time);
        $display("tb_category_set_insert_lookup_unit: FAIL");
        $finish;
    end

    // result side, with one long hold-off counted here
    initial begin
        int hold_left;
        bit hold_done;
        hold_left    = 0;
        hold_done    = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_if.ready = 1'b0;
                hold_left--;
            end else if (hold_request && !hold_done) begin
                hold_done    = 1;
                hold_left    = HOLD_CYCLES - 1;
                out_if.ready = 1'b0;
            end else begin
                out_if.ready = calm || ($urandom_range(99) >= 6);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready)
                tracker.check_outcome(out_if.present, out_if.status, out_if.fill_count);
            if (in_if.valid && in_if.ready)
                tracker.note_request(in_if.func, in_if.category);
        end
    end

    task automatic send_transfer(input logic func, input logic [CAT_W-1:0] cat);
        int gap;
        if (!calm && $urandom_range(99) < 6) begin
            gap = $urandom_range(1, 20);
            @(negedge i_clk);
            in_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid    = 1'b1;
        in_if.func     = func;
        in_if.category = cat;
        do
            @(posedge i_clk);
        while (in_if.ready !== 1'b1);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int               n;
        int               roll;
        bit               late;
        logic             f;
        logic [CAT_W-1:0] cat;

        tracker        = new();
        calm           = 0;
        hold_request   = 0;
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.func     = FUNC_ADD;
        in_if.category = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty set, holes appended and reused, extreme values
        send_transfer(FUNC_QUERY, '0);
        send_transfer(FUNC_QUERY, '1);
        send_transfer(FUNC_ADD,   '0);
        send_transfer(FUNC_QUERY, '0);
        send_transfer(FUNC_ADD,   '0);
        send_transfer(FUNC_ADD,   '1);
        send_transfer(FUNC_QUERY, '0);
        send_transfer(FUNC_ADD,   64'd1);
        send_transfer(FUNC_ADD,   64'h8000_0000_0000_0000);
        send_transfer(FUNC_QUERY, 64'h8000_0000_0000_0000);
        send_transfer(FUNC_QUERY, 64'h7fff_ffff_ffff_ffff);
        send_transfer(FUNC_ADD,   '0);
        send_transfer(FUNC_QUERY, '0);
        send_transfer(FUNC_ADD,   64'haaaa_aaaa_aaaa_aaaa);
        send_transfer(FUNC_ADD,   64'h5555_5555_5555_5555);
        send_transfer(FUNC_ADD,   64'd1);
        send_transfer(FUNC_QUERY, 64'haaaa_aaaa_aaaa_aaaa);
        send_transfer(FUNC_ADD,   '1);
        send_transfer(FUNC_QUERY, 64'd2);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 700 && n < 1000);
            if (n == 300)
                hold_request = 1;
            if (n == 1100)
                wait_for_drain();
            // the set is kept sparse at first, then driven to full
            late = (n >= 1200);
            roll = $urandom_range(99);
            if (roll < (late ? 30 : 10)) begin
                f    = FUNC_ADD;
                roll = $urandom_range(99);
                if (roll < (late ? 50 : 8))
                    cat = ($urandom_range(4) == 0) ? '0 : {$urandom, $urandom};
                else
                    cat = tracker.any_member();
            end else begin
                f    = FUNC_QUERY;
                roll = $urandom_range(99);
                if (roll < 50)
                    cat = tracker.any_member();
                else if (roll < 65)
                    cat = '0;
                else if (roll < 75) begin
                    case ($urandom_range(2))
                        0:       cat = 64'd1 << $urandom_range(63);
                        1:       cat = ~(64'd1 << $urandom_range(63));
                        default: cat = '1;
                    endcase
                end else
                    cat = {$urandom, $urandom};
            end
            send_transfer(f, cat);
        end
        calm = 0;

        wait_for_drain();
        repeat (40) @(posedge i_clk);
        if (tracker.outstanding() != 0) begin
            $display("%0t: %0d results never arrived", $time, tracker.outstanding());
            tracker.errors++;
        end

        $display("covered %0d adds and %0d queries, %0d found present, %0d refused as full",
                 tracker.n_add, tracker.n_query, tracker.n_found, tracker.n_refused);
        $display("checked %0d results, peak fill %0d of %0d, %0d errors",
                 tracker.n_checked, tracker.peak_fill, CAPACITY, tracker.errors);
        if (tracker.errors == 0)
            $display("tb_category_set_insert_lookup_unit: PASS");
        else
            $display("tb_category_set_insert_lookup_unit: FAIL");
        $finish;
    end

endmodule
